// ===== hdl/gzip_header_length_checker_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the gzip header length checker
// Clocked assertion forms used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef GZIP_HEADER_LENGTH_CHECKER_UNIT_ASSERT_SVH
`define GZIP_HEADER_LENGTH_CHECKER_UNIT_ASSERT_SVH

// Property that is checked only outside reset.
`define GZHLC_ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that is checked at every edge, reset included.
`define GZHLC_ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/gzhlc_pkg.sv =====
// ----------------------------------------------------------------------------
// gzip header length checker package
// Byte codes, phase codes, flag masks and the section selection function.
// ----------------------------------------------------------------------------
package gzhlc_pkg;

  localparam int DATA_BITS      = 8;
  localparam int OUT_BITS       = 20;
  localparam int COUNT_BITS_DEF = 20;
  localparam int FIXED_HDR_LEN  = 10;
  localparam int PHASE_BITS     = 4;
  localparam int FLAG_BITS      = 5;
  localparam int XLEN_BITS      = 16;

  localparam logic [DATA_BITS-1:0] MAGIC0_BYTE  = 8'h1F;
  localparam logic [DATA_BITS-1:0] MAGIC1_BYTE  = 8'h8B;
  localparam logic [DATA_BITS-1:0] METHOD_BYTE  = 8'h08;
  localparam logic [DATA_BITS-1:0] FLG_RESERVED = 8'hE0;

  // Flag bit positions inside the stored five flag bits.
  localparam int FLG_CRC     = 1;
  localparam int FLG_EXTRA   = 2;
  localparam int FLG_NAME    = 3;
  localparam int FLG_COMMENT = 4;

  // Parser phases.
  localparam logic [PHASE_BITS-1:0] PH_MAGIC0  = 4'd0;
  localparam logic [PHASE_BITS-1:0] PH_MAGIC1  = 4'd1;
  localparam logic [PHASE_BITS-1:0] PH_METHOD  = 4'd2;
  localparam logic [PHASE_BITS-1:0] PH_FLAGS   = 4'd3;
  localparam logic [PHASE_BITS-1:0] PH_SKIP    = 4'd4;
  localparam logic [PHASE_BITS-1:0] PH_XLEN_LO = 4'd5;
  localparam logic [PHASE_BITS-1:0] PH_XLEN_HI = 4'd6;
  localparam logic [PHASE_BITS-1:0] PH_NAME    = 4'd7;
  localparam logic [PHASE_BITS-1:0] PH_COMMENT = 4'd8;
  localparam logic [PHASE_BITS-1:0] PH_DONE    = 4'd9;

  // Control part of the parser state.
  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic [FLAG_BITS-1:0]  flags;
    logic                  bad;
  } parse_ctl_t;

  // Outcome of moving on to the next optional section.
  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic [FLAG_BITS-1:0]  flags;
    logic                  add_crc;
  } sect_t;

  // Picks the next optional section in header order and clears its flag.
  function automatic sect_t sect_pick(input logic [FLAG_BITS-1:0] flags);
    sect_t s;
    s.flags   = flags;
    s.add_crc = 1'b0;
    if (flags[FLG_EXTRA]) begin
      s.flags[FLG_EXTRA] = 1'b0;
      s.phase = PH_XLEN_LO;
    end else if (flags[FLG_NAME]) begin
      s.flags[FLG_NAME] = 1'b0;
      s.phase = PH_NAME;
    end else if (flags[FLG_COMMENT]) begin
      s.flags[FLG_COMMENT] = 1'b0;
      s.phase = PH_COMMENT;
    end else if (flags[FLG_CRC]) begin
      s.flags[FLG_CRC] = 1'b0;
      s.add_crc = 1'b1;
      s.phase = PH_SKIP;
    end else begin
      s.phase = PH_DONE;
    end
    return s;
  endfunction

endpackage

// ===== hdl/gzhlc_parse.sv =====
// ----------------------------------------------------------------------------
// gzip header parser step
// Next parser state for one byte and the result for a final byte.
// ----------------------------------------------------------------------------
module gzhlc_parse #(
  parameter int COUNT_BITS = gzhlc_pkg::COUNT_BITS_DEF
) (
  input  gzhlc_pkg::parse_ctl_t              ctl,
  input  logic [COUNT_BITS-1:0]              byte_count,
  input  logic [COUNT_BITS-1:0]              header_end,
  input  logic [gzhlc_pkg::DATA_BITS-1:0]    extra_len_low,
  input  logic [gzhlc_pkg::DATA_BITS-1:0]    data_byte,
  output gzhlc_pkg::parse_ctl_t              ctl_next,
  output logic [COUNT_BITS-1:0]              byte_count_next,
  output logic [COUNT_BITS-1:0]              header_end_next,
  output logic [gzhlc_pkg::DATA_BITS-1:0]    extra_len_low_next,
  output logic [gzhlc_pkg::OUT_BITS-1:0]     header_length,
  output logic                               header_found
);
  import gzhlc_pkg::*;

  localparam int CW = COUNT_BITS;
  localparam int WW = OUT_BITS + COUNT_BITS;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                            input logic [XLEN_BITS-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {{(CW + 1 - XLEN_BITS){1'b0}}, b};
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  logic [CW-1:0]        len;
  logic [PHASE_BITS-1:0] ph;
  logic [FLAG_BITS-1:0] fl;
  logic [CW-1:0]        he;
  logic [DATA_BITS-1:0] xl;
  logic                 bad;
  sect_t                s_skip1;
  sect_t                s_skip2;
  sect_t                s_term;
  logic [CW-1:0]        he_eff;
  logic                 ph_ok;
  logic                 hit;
  logic [WW-1:0]        wide;

  always_comb begin
    len     = sat_add(byte_count, XLEN_BITS'(1));
    ph      = ctl.phase;
    fl      = ctl.flags;
    he      = header_end;
    xl      = extra_len_low;
    bad     = ctl.bad;
    s_skip1 = sect_pick(fl);
    s_skip2 = sect_pick(s_skip1.flags);
    s_term  = sect_pick(fl);

    if (!bad) begin
      // Leave a finished skip region before looking at the byte. The second
      // pass can only follow the CRC skip, so it never adds to the end again.
      if (ph == PH_SKIP && byte_count >= he) begin
        ph = s_skip1.phase;
        fl = s_skip1.flags;
        if (s_skip1.add_crc) begin
          he = sat_add(he, XLEN_BITS'(2));
        end
        if (ph == PH_SKIP && byte_count >= he) begin
          ph = s_skip2.phase;
          fl = s_skip2.flags;
        end
      end

      case (ph)
        PH_MAGIC0: begin
          if (data_byte != MAGIC0_BYTE) bad = 1'b1; else ph = PH_MAGIC1;
        end
        PH_MAGIC1: begin
          if (data_byte != MAGIC1_BYTE) bad = 1'b1; else ph = PH_METHOD;
        end
        PH_METHOD: begin
          if (data_byte != METHOD_BYTE) bad = 1'b1; else ph = PH_FLAGS;
        end
        PH_FLAGS: begin
          if ((data_byte & FLG_RESERVED) != '0) begin
            bad = 1'b1;
          end else begin
            fl = data_byte[FLAG_BITS-1:0];
            he = CW'(FIXED_HDR_LEN);
            ph = PH_SKIP;
          end
        end
        PH_XLEN_LO: begin
          xl = data_byte;
          ph = PH_XLEN_HI;
        end
        PH_XLEN_HI: begin
          he = sat_add(len, {data_byte, xl});
          ph = PH_SKIP;
        end
        PH_NAME, PH_COMMENT: begin
          he = len;
          if (data_byte == '0) begin
            s_term = sect_pick(fl);
            ph = s_term.phase;
            fl = s_term.flags;
            if (s_term.add_crc) begin
              he = sat_add(len, XLEN_BITS'(2));
            end
          end
        end
        default: begin
        end
      endcase
    end

    // On the final byte an open name or comment ends at the buffer end and
    // only a pending CRC still adds to the header.
    he_eff = fl[FLG_CRC] ? sat_add(he, XLEN_BITS'(2)) : he;
    ph_ok  = (ph inside {PH_DONE, PH_NAME, PH_COMMENT}) ||
             (ph == PH_SKIP && he <= len && !fl[FLG_EXTRA]);
    hit    = !bad && len >= CW'(FIXED_HDR_LEN) && ph_ok && he_eff <= len;
    wide   = hit ? WW'(he_eff) : '0;
    header_length = (wide > WW'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}}
                                                   : wide[OUT_BITS-1:0];
    header_found  = header_length != '0;

    ctl_next.phase     = ph;
    ctl_next.flags     = fl;
    ctl_next.bad       = bad;
    byte_count_next    = len;
    header_end_next    = he;
    extra_len_low_next = xl;
  end

endmodule

// ===== hdl/gzip_header_length_checker_unit.sv =====
// ----------------------------------------------------------------------------
// gzip header length checker: the final byte of a buffer goes through the
// input and output registers to the result word. One byte per cycle while
// no final byte waits on a stalled output; other bytes give no output.
// Synchronous active-high reset clears the parser to the first magic byte.
// ----------------------------------------------------------------------------
module gzip_header_length_checker_unit #(
  parameter int COUNT_BITS = gzhlc_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [gzhlc_pkg::DATA_BITS-1:0]  data_byte,
  input  logic                             last_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [gzhlc_pkg::OUT_BITS-1:0]   header_length,
  output logic                             header_found
);
  import gzhlc_pkg::*;

  // Input register. A byte sits here while the parser step works on it; it
  // is held only when it is a final byte and the output register still
  // holds a result that has not been taken.
  logic                  s1_valid;
  logic [DATA_BITS-1:0]  s1_data;
  logic                  s1_last;
  logic                  s1_go;

  // Parser state carried from byte to byte within one buffer.
  parse_ctl_t            ctl;
  logic [COUNT_BITS-1:0] byte_count;
  logic [COUNT_BITS-1:0] header_end;
  logic [DATA_BITS-1:0]  extra_len_low;

  parse_ctl_t            ctl_next;
  logic [COUNT_BITS-1:0] byte_count_next;
  logic [COUNT_BITS-1:0] header_end_next;
  logic [DATA_BITS-1:0]  extra_len_low_next;
  logic [OUT_BITS-1:0]   res_length;
  logic                  res_found;

  // Only a final byte needs room in the output register; all other bytes
  // move through whatever the output side does.
  assign s1_go    = s1_valid && (!s1_last || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= data_byte;
      s1_last <= last_byte;
    end
  end

  gzhlc_parse #(
    .COUNT_BITS(COUNT_BITS)
  ) u_parse (
    .ctl               (ctl),
    .byte_count        (byte_count),
    .header_end        (header_end),
    .extra_len_low     (extra_len_low),
    .data_byte         (s1_data),
    .ctl_next          (ctl_next),
    .byte_count_next   (byte_count_next),
    .header_end_next   (header_end_next),
    .extra_len_low_next(extra_len_low_next),
    .header_length     (res_length),
    .header_found      (res_found)
  );

  // After the final byte of a buffer the parser starts over, so the next
  // byte is taken as the first byte of a new buffer.
  always_ff @(posedge clk) begin
    if (rst || (s1_go && s1_last)) begin
      ctl.phase     <= PH_MAGIC0;
      ctl.flags     <= '0;
      ctl.bad       <= 1'b0;
      byte_count    <= '0;
      header_end    <= COUNT_BITS'(FIXED_HDR_LEN);
      extra_len_low <= '0;
    end else if (s1_go) begin
      ctl           <= ctl_next;
      byte_count    <= byte_count_next;
      header_end    <= header_end_next;
      extra_len_low <= extra_len_low_next;
    end
  end

  // Output register. It holds its word while the receiver stalls and takes
  // a new result in the same cycle the old one leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      header_length <= res_length;
      header_found  <= res_found;
    end
  end

endmodule

// ===== hdl/gzhlc_checker.sv =====
// ----------------------------------------------------------------------------
// gzip header length checker port checks
// Watches the result channel of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`include "gzip_header_length_checker_unit_assert.svh"

module gzhlc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [gzhlc_pkg::OUT_BITS-1:0] header_length,
  input logic                           header_found
);
  import gzhlc_pkg::*;

  `GZHLC_ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(header_length) && $stable(header_found), "Stalled result word changed")
  `GZHLC_ASSERT_CLK(a_found_match, clk, rst, out_valid |-> header_found == (header_length != '0), "Found flag disagrees with length")
  `GZHLC_ASSERT_CLK(a_min_length, clk, rst, out_valid && header_found |-> header_length >= OUT_BITS'(FIXED_HDR_LEN), "Header shorter than the fixed part")
  `GZHLC_ASSERT_ANY(a_reset_idle, clk, rst |=> !out_valid, "Result word present after reset")

endmodule

bind gzip_header_length_checker_unit gzhlc_checker u_gzhlc_checker (.*);
